// ----- hdl/icmp_prm_pkg.sv -----
package icmp_prm_pkg;

    localparam int MAX_PACKET_BYTES = 1024;
    localparam int POS_W            = 11;
    localparam int HDR_W            = 6;
    localparam int TDATA_IN_W       = 8;
    localparam int TDATA_OUT_W      = 40;
    localparam int TUSER_OUT_W      = 2;

    localparam logic [POS_W-1:0] MAX_POS      = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] ICMP_HDR_LEN = POS_W'(8);

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    localparam logic [1:0] ST_MATCH     = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_OTHER     = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    localparam logic [1:0] CFG_IDENT    = 2'd0;
    localparam logic [1:0] CFG_SEQUENCE = 2'd1;
    localparam logic [1:0] CFG_TARGET   = 2'd2;

    typedef struct packed {
        logic [15:0] expected_ident;
        logic [15:0] expected_sequence;
        logic [31:0] target_address;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        reply_kind;
        logic [31:0] responder_ip;
        logic        reached_target;
    } result_t;

endpackage

// ----- hdl/icmp_prm_parser.sv -----
module icmp_prm_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  logic                  end_of_packet,
    input  icmp_prm_pkg::cfg_t    cfg,
    output icmp_prm_pkg::result_t result
);
    import icmp_prm_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [HDR_W-1:0] ohb_reg, ohb_next;
    logic [HDR_W-1:0] ihb_reg, ihb_next;
    logic [7:0]       type_reg, type_next;
    logic [31:0]      src_reg, src_next;
    logic [15:0]      ident_reg, ident_next;
    logic [15:0]      seq_reg, seq_next;

    logic [POS_W-1:0] len;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] hlim;
    logic             capture;
    logic             too_short;
    logic [1:0]       status;

    always_comb begin
        pos_next   = pos_reg;
        ohb_next   = ohb_reg;
        ihb_next   = ihb_reg;
        type_next  = type_reg;
        src_next   = src_reg;
        ident_next = ident_reg;
        seq_next   = seq_reg;
        base       = '0;
        capture    = 1'b0;
        len        = MAX_POS;

        if (pos_reg < MAX_POS) begin
            if (pos_reg == '0) begin
                ohb_next = {rx_byte[3:0], 2'b00};
            end
            if (pos_reg >= POS_W'(12) && pos_reg <= POS_W'(15)) begin
                case (pos_reg[1:0])
                    2'd0:    src_next[31:24] = rx_byte;
                    2'd1:    src_next[23:16] = rx_byte;
                    2'd2:    src_next[15:8]  = rx_byte;
                    default: src_next[7:0]   = rx_byte;
                endcase
            end
            if (pos_reg == POS_W'(ohb_next)) begin
                type_next = rx_byte;
            end
            if (type_next == TYPE_ECHO_REPLY) begin
                base    = POS_W'(ohb_next);
                capture = 1'b1;
            end else if (type_next == TYPE_TIME_EXCEEDED) begin
                // quoted inner header follows the 8 byte icmp header
                if (pos_reg == POS_W'(ohb_next) + ICMP_HDR_LEN) begin
                    ihb_next = {rx_byte[3:0], 2'b00};
                end
                base    = POS_W'(ohb_next) + ICMP_HDR_LEN + POS_W'(ihb_next);
                capture = 1'b1;
            end
            if (capture) begin
                if (pos_reg == base + POS_W'(4)) ident_next[15:8] = rx_byte;
                if (pos_reg == base + POS_W'(5)) ident_next[7:0]  = rx_byte;
                if (pos_reg == base + POS_W'(6)) seq_next[15:8]   = rx_byte;
                if (pos_reg == base + POS_W'(7)) seq_next[7:0]    = rx_byte;
            end
            pos_next = pos_reg + POS_W'(1);
            len      = pos_reg + POS_W'(1);
        end

        hlim      = POS_W'(ohb_next) + ICMP_HDR_LEN;
        too_short = len < hlim;
        if (too_short) begin
            status = ST_SHORT;
        end else if (type_next == TYPE_ECHO_REPLY) begin
            status = ST_MATCH;
        end else if (type_next == TYPE_TIME_EXCEEDED) begin
            if (len < hlim + POS_W'(1) ||
                len < hlim + POS_W'(ihb_next) + ICMP_HDR_LEN) begin
                status = ST_SHORT;
            end else begin
                status = ST_MATCH;
            end
        end else begin
            status = ST_OTHER;
        end
        if (status == ST_MATCH &&
            (ident_next != cfg.expected_ident || seq_next != cfg.expected_sequence)) begin
            status = ST_MISMATCH;
        end

        result.status         = status;
        result.reply_kind     = (type_next == TYPE_TIME_EXCEEDED);
        result.responder_ip   = src_next;
        result.reached_target = (status == ST_MATCH) && (src_next == cfg.target_address);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_packet)) begin
            pos_reg   <= '0;
            ohb_reg   <= '0;
            ihb_reg   <= '0;
            type_reg  <= '0;
            src_reg   <= '0;
            ident_reg <= '0;
            seq_reg   <= '0;
        end else if (step) begin
            pos_reg   <= pos_next;
            ohb_reg   <= ohb_next;
            ihb_reg   <= ihb_next;
            type_reg  <= type_next;
            src_reg   <= src_next;
            ident_reg <= ident_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

// ----- hdl/icmp_prm_out.sv -----
module icmp_prm_out (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  icmp_prm_pkg::result_t                 result,
    output logic                                  slot_free,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [icmp_prm_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic [icmp_prm_pkg::TUSER_OUT_W-1:0]  m_tuser
);
    import icmp_prm_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {6'b0, data_reg.responder_ip, data_reg.status};
    assign m_tuser   = {data_reg.reached_target, data_reg.reply_kind};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// ----- hdl/icmp_probe_reply_matcher.sv -----
// channel   dir  handshake        tdata                                  tuser / tlast
// s_        in   s_tvalid/tready  [7:0] rx_byte                          tlast end_of_packet
// m_        out  m_tvalid/tready  [1:0] status, [33:2] responder_ip      [0] reply_kind,
//                                 [39:34] zero                           [1] reached_target
// cfg_      in   cfg_wr_en        cfg_addr selects register, cfg_wr_data
//
// one byte per cycle but for stalls: input register, offset compares, result register
// the result register loads as the last byte steps out of the input register
// bytes that end no packet pass the input register without waiting on m_tready
// a last byte stalls in the input register only while the result register is held,
// and s_tready stays low until it moves on
// aresetn is synchronous and clears packet state and configuration
module icmp_probe_reply_matcher (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [icmp_prm_pkg::TDATA_IN_W-1:0]   s_tdata,    // [7:0] rx_byte
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [icmp_prm_pkg::TDATA_OUT_W-1:0]  m_tdata,    // status, responder_ip
    output logic [icmp_prm_pkg::TUSER_OUT_W-1:0]  m_tuser,    // reply_kind, reached_target
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_addr,
    input  logic [31:0]                           cfg_wr_data
);
    import icmp_prm_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    logic [7:0] in_byte_reg;
    logic      in_last_reg;
    logic      step;
    logic      slot_free;
    result_t   result;

    // a byte that ends no packet never needs the result slot
    assign step     = in_valid_reg && (!in_last_reg || slot_free);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDENT:    cfg_reg.expected_ident    <= cfg_wr_data[15:0];
                CFG_SEQUENCE: cfg_reg.expected_sequence <= cfg_wr_data[15:0];
                CFG_TARGET:   cfg_reg.target_address    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    icmp_prm_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .end_of_packet (in_last_reg),
        .cfg           (cfg_reg),
        .result        (result)
    );

    icmp_prm_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && in_last_reg),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- sim/icmp_probe_reply_matcher_chk.sv -----
`timescale 1ns / 100ps

module icmp_probe_reply_matcher_chk (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [icmp_prm_pkg::TDATA_IN_W-1:0]  s_tdata,     // [7:0] rx_byte
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [icmp_prm_pkg::TDATA_OUT_W-1:0] m_tdata,     // status, responder_ip, zero
    input  logic [icmp_prm_pkg::TUSER_OUT_W-1:0] m_tuser,     // reply_kind, reached_target
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_addr,
    input  logic [31:0]                          cfg_wr_data,
    output int                                   fault_count,
    output int                                   outstanding
);
    import icmp_prm_pkg::*;

    localparam int HDR_BYTES = ICMP_HDR_LEN;

    // configuration as the block should hold it
    logic [15:0] want_ident;
    logic [15:0] want_seq;
    logic [31:0] want_target;

    // per-packet parse state
    int          byte_pos;
    logic [5:0]  outer_len;
    logic [5:0]  inner_len;
    logic [7:0]  icmp_type;
    logic [31:0] src_ip;
    logic [15:0] got_ident;
    logic [15:0] got_seq;

    result_t     verdict_q[$];
    int          shown;

    task automatic clear_packet();
        byte_pos  = 0;
        outer_len = '0;
        inner_len = '0;
        icmp_type = '0;
        src_ip    = '0;
        got_ident = '0;
        got_seq   = '0;
    endtask

    task automatic grab_id_seq(input int pos, input int base, input logic [7:0] b);
        if (pos == base + 4) got_ident[15:8] = b;
        if (pos == base + 5) got_ident[7:0]  = b;
        if (pos == base + 6) got_seq[15:8]   = b;
        if (pos == base + 7) got_seq[7:0]    = b;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        int          pos;
        int          h;
        int          ih;
        int          len;
        result_t     r;
        pos = byte_pos;
        if (pos < MAX_PACKET_BYTES) begin
            if (pos == 0) outer_len = {b[3:0], 2'b00};
            h = outer_len;
            if (pos >= 12 && pos <= 15) src_ip[(15 - pos) * 8 +: 8] = b;
            if (pos == h) icmp_type = b;
            if (icmp_type == TYPE_ECHO_REPLY) begin
                grab_id_seq(pos, h, b);
            end else if (icmp_type == TYPE_TIME_EXCEEDED) begin
                if (pos == h + HDR_BYTES) inner_len = {b[3:0], 2'b00};
                ih = inner_len;
                grab_id_seq(pos, h + HDR_BYTES + ih, b);
            end
            byte_pos = pos + 1;
            len      = pos + 1;
        end else begin
            len = MAX_PACKET_BYTES;
        end

        if (is_last) begin
            h  = outer_len;
            ih = inner_len;
            if (len < h + HDR_BYTES) begin
                r.status = ST_SHORT;
            end else if (icmp_type == TYPE_ECHO_REPLY) begin
                r.status = ST_MATCH;
            end else if (icmp_type == TYPE_TIME_EXCEEDED) begin
                // the inner ihl byte and the quoted icmp header must both be in
                if (len < h + HDR_BYTES + 1 || len < h + HDR_BYTES + ih + HDR_BYTES)
                    r.status = ST_SHORT;
                else
                    r.status = ST_MATCH;
            end else begin
                r.status = ST_OTHER;
            end
            if (r.status == ST_MATCH && (got_ident != want_ident || got_seq != want_seq))
                r.status = ST_MISMATCH;
            r.reply_kind     = (icmp_type == TYPE_TIME_EXCEEDED);
            r.responder_ip   = src_ip;
            r.reached_target = (r.status == ST_MATCH) && (src_ip == want_target);
            verdict_q.push_back(r);
            clear_packet();
        end
    endtask

    task automatic check_reply();
        result_t     w;
        logic [1:0]  act_status;
        logic        act_kind;
        logic [31:0] act_ip;
        logic        act_reached;
        logic [5:0]  act_pad;
        act_status  = m_tdata[1:0];
        act_ip      = m_tdata[33:2];
        act_pad     = m_tdata[39:34];
        act_kind    = m_tuser[0];
        act_reached = m_tuser[1];
        if (verdict_q.size() == 0) begin
            fault_count++;
            if (shown < 10) begin
                shown++;
                $display("unexpected item: status %0d kind %0d ip %h reached %0d",
                         act_status, act_kind, act_ip, act_reached);
            end
        end else begin
            w = verdict_q.pop_front();
            if (act_status !== w.status || act_kind !== w.reply_kind ||
                act_ip !== w.responder_ip || act_reached !== w.reached_target ||
                act_pad !== 6'd0) begin
                fault_count++;
                if (shown < 10) begin
                    shown++;
                    $display("item differs: expected status %0d kind %0d ip %h reached %0d",
                             w.status, w.reply_kind, w.responder_ip, w.reached_target);
                    $display("              got      status %0d kind %0d ip %h reached %0d pad %h",
                             act_status, act_kind, act_ip, act_reached, act_pad);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            want_ident  = '0;
            want_seq    = '0;
            want_target = '0;
            clear_packet();
            verdict_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IDENT:    want_ident  = cfg_wr_data[15:0];
                    CFG_SEQUENCE: want_seq    = cfg_wr_data[15:0];
                    CFG_TARGET:   want_target = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) absorb_byte(s_tdata[7:0], s_tlast);
            if (m_tvalid && m_tready) check_reply();
        end
        outstanding <= verdict_q.size();
    end

endmodule

// ----- sim/icmp_probe_reply_matcher_tb.sv -----
`timescale 1ns / 100ps

module icmp_probe_reply_matcher_tb;
    import icmp_prm_pkg::*;

    localparam int CYCLE_LIMIT = 40000;

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic [TDATA_IN_W-1:0]  s_tdata     = '0;
    logic                   s_tlast     = 1'b0;
    logic                   m_tready    = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [1:0]             cfg_addr    = CFG_IDENT;
    logic [31:0]            cfg_wr_data = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;

    int          fault_count;
    int          outstanding;
    int unsigned cycles = 0;
    bit          calm   = 1'b0;     // no idling on either side

    logic [15:0] probe_id  = '0;
    logic [15:0] probe_seq = '0;
    logic [31:0] trace_dst = '0;
    logic [7:0]  pkt_bytes[];
    int          sent_bytes = 0;
    int          sent_pkts  = 0;
    int          phase_bytes;
    int          phase_pkts;

    icmp_probe_reply_matcher u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    icmp_probe_reply_matcher_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("icmp_probe_reply_matcher: mismatch");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        sent_bytes += pkt_bytes.size();
        sent_pkts++;
    endtask

    // sender holds off until every item that is owed has come back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] id, input logic [15:0] sq,
                              input logic [31:0] dst);
        probe_id    = id;
        probe_seq   = sq;
        trace_dst   = dst;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_IDENT;
        cfg_wr_data <= {16'd0, id};
        @(posedge aclk);
        cfg_addr    <= CFG_SEQUENCE;
        cfg_wr_data <= {16'd0, sq};
        @(posedge aclk);
        cfg_addr    <= CFG_TARGET;
        cfg_wr_data <= dst;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic void put(input int idx, input logic [7:0] v);
        if (idx < pkt_bytes.size()) pkt_bytes[idx] = v;
    endfunction

    // random filler with the header fields that steer the parse laid on top
    task automatic form_packet(input int ihl, input logic [7:0] kind_byte, input int iihl,
                               input logic [15:0] id, input logic [15:0] sq,
                               input logic [31:0] src, input int len);
        int h;
        int base;
        pkt_bytes = new[len];
        foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom);
        h = ihl * 4;
        put(0, {4'($urandom), 4'(ihl)});
        for (int k = 0; k < 4; k++) put(12 + k, src[31 - 8 * k -: 8]);
        put(h, kind_byte);
        base = h;
        if (kind_byte == TYPE_TIME_EXCEEDED) begin
            put(h + 8, {4'($urandom), 4'(iihl)});
            base = h + 8 + iihl * 4;
        end
        put(base + 4, id[15:8]);
        put(base + 5, id[7:0]);
        put(base + 6, sq[15:8]);
        put(base + 7, sq[7:0]);
    endtask

    function automatic logic [15:0] near_value(input logic [15:0] want);
        int r;
        r = $urandom_range(99);
        if (r < 80) return want;
        if (r < 90) return want ^ (16'd1 << $urandom_range(15));
        return 16'($urandom);
    endfunction

    task automatic random_reply();
        int          shape;
        int          ihl;
        int          iihl;
        int          need;
        int          len;
        logic [7:0]  kind_byte;
        logic [31:0] src;
        shape = $urandom_range(99);
        ihl   = ($urandom_range(99) < 75) ? 5 : $urandom_range(15);
        iihl  = ($urandom_range(99) < 75) ? 5 : $urandom_range(15);
        src   = ($urandom_range(1) != 0) ? trace_dst : $urandom;
        if (shape < 40) begin
            kind_byte = TYPE_ECHO_REPLY;
        end else if (shape < 75) begin
            kind_byte = TYPE_TIME_EXCEEDED;
        end else if (shape < 90) begin
            kind_byte = ($urandom_range(1) != 0) ? TYPE_TIME_EXCEEDED : TYPE_ECHO_REPLY;
        end else begin
            do kind_byte = 8'($urandom);
            while (kind_byte == TYPE_ECHO_REPLY || kind_byte == TYPE_TIME_EXCEEDED);
        end
        need = (kind_byte == TYPE_TIME_EXCEEDED) ? ihl * 4 + 16 + iihl * 4 : ihl * 4 + 8;
        if (shape >= 75 && shape < 83)
            len = $urandom_range(need - 1, 1);
        else
            len = need + $urandom_range(12);
        if (shape >= 95) begin
            // plain noise
            len = $urandom_range(64, 1);
            pkt_bytes = new[len];
            foreach (pkt_bytes[i]) pkt_bytes[i] = 8'($urandom);
        end else begin
            form_packet(ihl, kind_byte, iihl, near_value(probe_id), near_value(probe_seq),
                        src, len);
        end
        send_packet();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of the registers
        form_packet(5, TYPE_ECHO_REPLY, 5, 16'd0, 16'd0, 32'd0, 28);
        send_packet();
        drain_replies();

        set_config(16'($urandom), 16'($urandom), $urandom);
        form_packet(5, TYPE_ECHO_REPLY, 5, probe_id, probe_seq, trace_dst, 28);
        send_packet();
        form_packet(5, TYPE_ECHO_REPLY, 5, probe_id, probe_seq, ~trace_dst, 29);
        send_packet();
        form_packet(5, TYPE_ECHO_REPLY, 5, probe_id, probe_seq ^ 16'd1, trace_dst, 30);
        send_packet();
        form_packet(5, TYPE_TIME_EXCEEDED, 5, probe_id, probe_seq, trace_dst, 56);
        send_packet();
        form_packet(15, TYPE_TIME_EXCEEDED, 15, probe_id, probe_seq, trace_dst, 136);
        send_packet();
        form_packet(5, TYPE_TIME_EXCEEDED, 0, probe_id, probe_seq, trace_dst, 36);
        send_packet();
        form_packet(5, 8'hFF, 5, probe_id, probe_seq, trace_dst, 28);
        send_packet();
        // too short: before the icmp header ends, before the inner ihl, before the inner ids
        form_packet(5, TYPE_ECHO_REPLY, 5, probe_id, probe_seq, trace_dst, 27);
        send_packet();
        form_packet(5, TYPE_TIME_EXCEEDED, 5, probe_id, probe_seq, trace_dst, 28);
        send_packet();
        form_packet(5, TYPE_TIME_EXCEEDED, 5, probe_id, probe_seq, trace_dst, 55);
        send_packet();
        form_packet(5, TYPE_ECHO_REPLY, 5, probe_id, probe_seq, trace_dst, 1);
        send_packet();
        // small ihl, icmp fields overlap the outer header
        form_packet(0, TYPE_ECHO_REPLY, 5, probe_id, probe_seq, trace_dst, 8);
        send_packet();
        form_packet(1, TYPE_ECHO_REPLY, 5, probe_id, probe_seq, trace_dst, 16);
        send_packet();
        form_packet(3, TYPE_TIME_EXCEEDED, 5, probe_id, probe_seq, trace_dst, 48);
        send_packet();
        pkt_bytes = new[24];
        foreach (pkt_bytes[i]) pkt_bytes[i] = 8'h00;
        send_packet();
        pkt_bytes = new[24];
        foreach (pkt_bytes[i]) pkt_bytes[i] = 8'hFF;
        send_packet();

        // overlong packet, sent with neither side idling
        drain_replies();
        calm <= 1'b1;
        form_packet(5, TYPE_TIME_EXCEEDED, 5, probe_id, probe_seq, trace_dst,
                    MAX_PACKET_BYTES + 2);
        send_packet();
        drain_replies();
        calm <= 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            drain_replies();
            case (ph)
                0:       set_config(16'h0000, 16'h0000, 32'h0000_0000);
                1:       set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
                default: set_config(16'($urandom), 16'($urandom), $urandom);
            endcase
            phase_bytes = sent_bytes;
            phase_pkts  = sent_pkts;
            while (sent_bytes - phase_bytes < 64 || sent_pkts - phase_pkts < 2)
                random_reply();
        end

        drain_replies();
        if (fault_count == 0) begin
            $display("icmp_probe_reply_matcher: match");
        end else begin
            $display("icmp_probe_reply_matcher: mismatch");
        end
        $finish;
    end

endmodule
